[hdl/lpct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpct_pkg
// Request codes, result kinds and the command/status bundles shared by the
// controller and datapath of the linear probe class table.
// ----------------------------------------------------------------------------
package lpct_pkg;

	localparam logic [1:0] REQ_FIND  = 2'd0;
	localparam logic [1:0] REQ_GET   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned LIMIT_W = 10;

	typedef enum logic [1:0] {
		RES_NONE   = 2'd0,
		RES_FOUND  = 2'd1,
		RES_INSERT = 2'd2,
		RES_FULL   = 2'd3
	} res_kind_t;

	typedef struct packed {
		logic      load_req;
		logic      hash_start;
		logic      pos_load;
		logic      pos_adv;
		logic      ins_write;
		logic      clr_start;
		logic      clr_step;
		logic      res_load;
		res_kind_t res_kind;
	} lpct_cmd_t;

	typedef struct packed {
		logic       hash_done;
		logic       slot_used;
		logic       key_hit;
		logic       probe_last;
		logic       clr_last;
		logic       count_ok;
		logic       out_busy;
		logic [1:0] new_req;
		logic [1:0] cur_req;
	} lpct_sts_t;

endpackage
`default_nettype wire

[hdl/lpct_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpct_if
// Handshake channels of the table: request, result and configuration write.
// ----------------------------------------------------------------------------
interface lpct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] elem_id;
	logic [31:0] class_key;
	logic [31:0] hash_code;

	modport source (output valid, req_type, elem_id, class_key, hash_code, input ready);
	modport sink   (input valid, req_type, elem_id, class_key, hash_code, output ready);
endinterface

interface lpct_res_if;
	logic        valid;
	logic        ready;
	logic        rep_valid;
	logic [31:0] rep_id;
	logic        inserted;
	logic        full_res;

	modport source (output valid, rep_valid, rep_id, inserted, full_res, input ready);
	modport sink   (input valid, rep_valid, rep_id, inserted, full_res, output ready);
endinterface

interface lpct_cfg_if;
	logic       valid;
	logic       ready;
	logic [9:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hdl/lpct_hash_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpct_hash_mod
// Reduces the hash to a slot index: a mask for power-of-two depths, otherwise
// a remainder by reciprocal multiplication, pipelined.
// ----------------------------------------------------------------------------
module lpct_hash_mod #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   hash,
	output logic               done,
	output logic [AW-1:0]      rem
);

	localparam bit IS_POW2 = (DEPTH & (DEPTH - 1)) == 0;

	generate
		if (IS_POW2) begin : g_mask
			logic          done_q;
			logic [AW-1:0] rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					rem_q <= hash[AW-1:0];
				end
			end

			assign done = done_q;
			assign rem  = rem_q;
		end else begin : g_div
			localparam int          SHIFT = 32 + AW;
			localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
			localparam logic [32:0] MUL   = 33'(RECIP);
			localparam logic [31:0] DEP   = 32'(DEPTH);

			logic          stg_s1;
			logic          stg_s2;
			logic          stg_s3;
			logic          done_q;
			logic [31:0]   h_q;
			logic [64:0]   prod_s2;
			logic [31:0]   qd_s3;
			logic [AW-1:0] r_q;
			logic [31:0]   quo;
			logic [31:0]   diff;

			always_comb begin
				quo  = 32'(prod_s2[64:SHIFT]);
				diff = h_q - qd_s3;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stg_s1 <= 1'b0;
					stg_s2 <= 1'b0;
					stg_s3 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					stg_s1 <= start;
					stg_s2 <= stg_s1;
					stg_s3 <= stg_s2;
					done_q <= stg_s3;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					h_q <= hash;
				end
				prod_s2 <= {32'd0, MUL} * {33'd0, h_q};
				qd_s3   <= quo * DEP;
				r_q     <= diff[AW-1:0];
			end

			assign done = done_q;
			assign rem  = r_q;
		end
	endgenerate

endmodule
`default_nettype wire

[hdl/lpct_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpct_datapath
// Slot memory, probe position, entry count, load limit and result register.
// ----------------------------------------------------------------------------
module lpct_datapath
	import lpct_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int SW    = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lpct_cmd_t          cmd,
	output lpct_sts_t               sts,
	input  wire logic [1:0]         in_req_type,
	input  wire logic [31:0]        in_elem_id,
	input  wire logic [31:0]        in_class_key,
	input  wire logic [31:0]        in_hash_code,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_rep_valid,
	output logic [31:0]             out_rep_id,
	output logic                    out_inserted,
	output logic                    out_full_res
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int W    = 1 + DATA_W + SW;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [W-1:0]       mem [DEPTH];
	logic [W-1:0]       rd_q;
	logic [1:0]         req_q;
	logic [SW-1:0]      id_q;
	logic [31:0]        key_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      n_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      count_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               res_valid_q;
	logic               rep_valid_q;
	logic [31:0]        rep_id_q;
	logic               inserted_q;
	logic               full_q;
	logic [AW-1:0]      hash_rem;
	logic               hash_done;
	logic [SW-1:0]      rd_elem;

	lpct_hash_mod #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.hash   (in_hash_code),
		.done   (hash_done),
		.rem    (hash_rem)
	);

	assign rd_elem = rd_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.ins_write) begin
			mem[pos_q] <= {1'b1, key_q, id_q};
		end
		rd_q <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_req_type;
			id_q  <= in_elem_id[SW-1:0];
			key_q <= in_class_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			n_q     <= '0;
			clr_q   <= '0;
			count_q <= '0;
			limit_q <= LIMIT_W'(716);
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.pos_load) begin
				pos_q <= hash_rem;
				n_q   <= '0;
			end else if (cmd.pos_adv) begin
				pos_q <= (pos_q == LAST) ? '0 : pos_q + AW'(1);
				n_q   <= n_q + AW'(1);
			end
			if (cmd.clr_start) begin
				clr_q   <= '0;
				count_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= (clr_q == LAST) ? '0 : clr_q + AW'(1);
			end
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rep_valid_q <= 1'b0;
			rep_id_q    <= '0;
			inserted_q  <= 1'b0;
			full_q      <= 1'b0;
			case (cmd.res_kind)
				RES_FOUND: begin
					rep_valid_q <= 1'b1;
					rep_id_q    <= 32'(rd_elem);
				end
				RES_INSERT: begin
					rep_valid_q <= 1'b1;
					rep_id_q    <= 32'(id_q);
					inserted_q  <= 1'b1;
				end
				RES_FULL: begin
					full_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts.hash_done  = hash_done;
		sts.slot_used  = rd_q[W-1];
		sts.key_hit    = rd_q[SW+DATA_W-1:SW] == key_q;
		sts.probe_last = n_q == LAST;
		sts.clr_last   = clr_q == LAST;
		sts.count_ok   = CMPW'(count_q) < CMPW'(limit_q);
		sts.out_busy   = res_valid_q & ~out_ready;
		sts.new_req    = in_req_type;
		sts.cur_req    = req_q;
	end

	assign out_valid     = res_valid_q;
	assign out_rep_valid = rep_valid_q;
	assign out_rep_id    = rep_id_q;
	assign out_inserted  = inserted_q;
	assign out_full_res  = full_q;

endmodule
`default_nettype wire

[hdl/lpct_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpct_ctrl
// Sequencer for clearing sweeps, hash reduction, slot probing and result
// hand-off.
// ----------------------------------------------------------------------------
module lpct_ctrl
	import lpct_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire lpct_sts_t sts,
	output lpct_cmd_t      cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;
	logic      pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q  <= RES_NONE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			pend_q  <= pend_d;
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		pend_d  = pend_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					if (pend_q) begin
						kind_d  = RES_NONE;
						pend_d  = 1'b0;
						state_d = S_DONE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					if (sts.new_req == REQ_CLEAR) begin
						cmd.clr_start = 1'b1;
						pend_d        = 1'b1;
						state_d       = S_CLEAR;
					end else if (sts.new_req == REQ_FIND || sts.new_req == REQ_GET) begin
						cmd.hash_start = 1'b1;
						state_d        = S_HASH;
					end else begin
						kind_d  = RES_NONE;
						state_d = S_DONE;
					end
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					cmd.pos_load = 1'b1;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = S_DONE;
				if (sts.slot_used && sts.key_hit) begin
					kind_d = RES_FOUND;
				end else if (!sts.slot_used) begin
					if (sts.cur_req == REQ_GET) begin
						if (sts.count_ok) begin
							cmd.ins_write = 1'b1;
							kind_d        = RES_INSERT;
						end else begin
							kind_d = RES_FULL;
						end
					end else begin
						kind_d = RES_NONE;
					end
				end else if (sts.probe_last) begin
					kind_d = (sts.cur_req == REQ_GET) ? RES_FULL : RES_NONE;
				end else begin
					cmd.pos_adv = 1'b1;
					state_d     = S_READ;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = kind_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/linear_probe_class_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_class_table_top
// Find, get-or-insert and clear on a linearly probed class table.
// Find/get: the result loads after the hash reduction and one memory read and compare
//   per probed slot; the reduction is a pipelined reciprocal remainder of the hash when
//   TABLE_DEPTH is not a power of two.
// Clear: every slot is cleared, one slot per cycle, before the result loads.
// One request at a time: the next transfer can come in the cycle after the result loads.
// Reset: a sweep clears all slots; requests wait.
// ----------------------------------------------------------------------------
module linear_probe_class_table_top
	import lpct_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int ID_BITS     = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lpct_req_if.sink    req,
	lpct_res_if.source  res,
	lpct_cfg_if.sink    cfg
);

	localparam int SW = (ID_BITS < 32) ? ID_BITS : 32;

	lpct_cmd_t cmd;
	lpct_sts_t sts;

	assign cfg.ready = 1'b1;

	lpct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpct_datapath #(
		.DEPTH (TABLE_DEPTH),
		.SW    (SW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_req_type   (req.req_type),
		.in_elem_id    (req.elem_id),
		.in_class_key  (req.class_key),
		.in_hash_code  (req.hash_code),
		.cfg_we        (cfg.valid),
		.cfg_data      (cfg.data),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.out_rep_valid (res.rep_valid),
		.out_rep_id    (res.rep_id),
		.out_inserted  (res.inserted),
		.out_full_res  (res.full_res)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while a request is in progress");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load && cmd.res_kind == RES_INSERT |=> res.valid && res.inserted)
		else $error("insert not reported");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.full_res |-> !res.rep_valid && !res.inserted)
		else $error("refused insert reports a representative");

	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !req.ready)
		else $error("request open during clearing sweep");

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear probe class table: a directed opening
// (empty table, collisions with wrap, misses on a foreign hash, unused code,
// clear, zero and extreme load limits), then random find/get/clear/unused
// traffic over a small pool of clustered classes. A scoreboard class keeps its
// own copy of the table and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
	import lpct_pkg::*;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_POOL    = 48;
	localparam int PHASE_ITEMS = 92;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] id;
		logic [31:0] key;
		logic [31:0] hash;
	} lookup_req_t;

	typedef struct packed {
		logic        rep_valid;
		logic [31:0] rep_id;
		logic        inserted;
		logic        full_res;
	} rep_res_t;

	class rep_scoreboard;
		bit                 used [TABLE_DEPTH];
		logic [31:0]        elem [TABLE_DEPTH];
		logic [31:0]        key_of [TABLE_DEPTH];
		int unsigned        entries;
		logic [LIMIT_W-1:0] limit;
		rep_res_t           rep_expected [$];
		int unsigned        errors;

		function new();
			limit   = 10'd716;
			entries = 0;
			errors  = 0;
			foreach (used[i]) used[i] = 1'b0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			limit = value;
		endfunction

		function int unsigned pending();
			return rep_expected.size();
		endfunction

		function void note_request(lookup_req_t r);
			rep_res_t    exp_res;
			int unsigned pos;
			int unsigned n;
			bit          ended;
			exp_res = '0;
			ended   = 1'b0;
			pos     = r.hash % TABLE_DEPTH;
			case (r.kind)
				REQ_CLEAR: begin
					foreach (used[i]) used[i] = 1'b0;
					entries = 0;
				end
				REQ_FIND, REQ_GET: begin
					for (n = 0; n < TABLE_DEPTH && !ended; n++) begin
						if (!used[pos] || key_of[pos] == r.key)
							ended = 1'b1;
						else
							pos = (pos + 1) % TABLE_DEPTH;
					end
					if (ended && used[pos]) begin
						exp_res.rep_valid = 1'b1;
						exp_res.rep_id    = elem[pos];
					end else if (r.kind == REQ_GET) begin
						if (!ended || entries >= limit) begin
							exp_res.full_res = 1'b1;
						end else begin
							used[pos]         = 1'b1;
							elem[pos]         = r.id;
							key_of[pos]       = r.key;
							entries++;
							exp_res.rep_valid = 1'b1;
							exp_res.rep_id    = r.id;
							exp_res.inserted  = 1'b1;
						end
					end
				end
				default: ;
			endcase
			rep_expected.push_back(exp_res);
		endfunction

		function void check_result(rep_res_t got);
			rep_res_t exp_res;
			if (rep_expected.size() == 0) begin
				$error("result transfer with no request outstanding");
				errors++;
				return;
			end
			exp_res = rep_expected.pop_front();
			if (got.rep_valid !== exp_res.rep_valid) begin
				$error("rep_valid: expected %0d, got %0d", exp_res.rep_valid, got.rep_valid);
				errors++;
			end
			if (got.rep_id !== exp_res.rep_id) begin
				$error("rep_id: expected %h, got %h", exp_res.rep_id, got.rep_id);
				errors++;
			end
			if (got.inserted !== exp_res.inserted) begin
				$error("inserted: expected %0d, got %0d", exp_res.inserted, got.inserted);
				errors++;
			end
			if (got.full_res !== exp_res.full_res) begin
				$error("full_res: expected %0d, got %0d", exp_res.full_res, got.full_res);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lpct_req_if req_ch ();
	lpct_res_if res_ch ();
	lpct_cfg_if cfg_ch ();

	linear_probe_class_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ID_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	rep_scoreboard board;
	bit            src_steady;
	bit            snk_steady;
	bit            hold_req;
	int unsigned   idle_cycles;
	logic [31:0]   class_keys [KEY_POOL];
	logic [9:0]    home_slot [KEY_POOL];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap(bit steady);
		return steady ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic send_request(logic [1:0] kind, logic [31:0] id, logic [31:0] key,
			logic [31:0] hash);
		int          gap;
		lookup_req_t r;
		gap = draw_gap(src_steady);
		r   = '{kind: kind, id: id, key: key, hash: hash};
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     = 1'b1;
		req_ch.req_type  = kind;
		req_ch.elem_id   = id;
		req_ch.class_key = key;
		req_ch.hash_code = hash;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(r);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		drain();
		cfg_ch.valid = 1'b1;
		cfg_ch.data  = value;
		do @(posedge clk); while (!cfg_ch.ready);
		board.set_limit(value);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic random_item();
		int          pick;
		int          k;
		logic [31:0] hash;
		logic [1:0]  kind;
		pick = $urandom_range(0, 99);
		k    = $urandom_range(0, KEY_POOL - 1);
		hash = $urandom();
		if ($urandom_range(0, 99) >= 8)
			hash[9:0] = home_slot[k];
		if (pick < 4)
			kind = REQ_CLEAR;
		else if (pick < 6)
			kind = REQ_UNUSED;
		else if (pick < 40)
			kind = REQ_FIND;
		else
			kind = REQ_GET;
		send_request(kind, $urandom(), class_keys[k], hash);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = draw_gap(snk_steady);
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			board.check_result('{rep_valid: res_ch.rep_valid, rep_id: res_ch.rep_id,
				inserted: res_ch.inserted, full_res: res_ch.full_res});
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [9:0] phase_limit [8];
		int         phase;
		int         i;
		board            = new();
		src_steady       = 1'b0;
		snk_steady       = 1'b0;
		hold_req         = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = REQ_FIND;
		req_ch.elem_id   = '0;
		req_ch.class_key = '0;
		req_ch.hash_code = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		phase_limit      = '{10'd3, 10'd1023, 10'd8, 10'd40, 10'd1, 10'd12, 10'd1023, 10'd25};
		for (i = 0; i < KEY_POOL; i++) begin
			class_keys[i] = $urandom();
			home_slot[i]  = (i % 2) ? 10'(1016 + $urandom_range(0, 15))
				: 10'(300 + $urandom_range(0, 19));
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// empty table, collision at the last slot with wrap to slot 0
		send_request(REQ_FIND, 32'h1234_5678, 32'hA5A5_0001, 32'hFFFF_FFFF);
		send_request(REQ_GET, 32'h0000_0000, 32'hA5A5_0001, 32'hFFFF_FFFF);
		send_request(REQ_GET, 32'hFFFF_FFFF, 32'hA5A5_0001, 32'hFFFF_FFFF);
		send_request(REQ_FIND, 32'h0BAD_F00D, 32'hA5A5_0001, 32'h0000_03FF);
		send_request(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_03FF);
		send_request(REQ_FIND, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// member looked up under a foreign hash is missed
		send_request(REQ_FIND, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0005);
		send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000, 32'h0000_0005);
		send_request(REQ_FIND, 32'h0000_0003, 32'h0000_0000, 32'hFFFF_FC05);
		send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_FIND, 32'h0000_0004, 32'hA5A5_0001, 32'hFFFF_FFFF);
		write_limit(10'd0);
		send_request(REQ_GET, 32'h0000_0005, 32'h0000_0011, 32'h0000_0010);
		send_request(REQ_FIND, 32'h0000_0006, 32'h0000_0011, 32'h0000_0010);
		write_limit(10'd1);
		send_request(REQ_GET, 32'h0000_0007, 32'h0000_0011, 32'h0000_0010);
		send_request(REQ_GET, 32'h0000_0008, 32'h0000_0022, 32'h0000_0010);
		send_request(REQ_GET, 32'h0000_0009, 32'h0000_0011, 32'h0000_0010);
		write_limit(10'd1023);
		send_request(REQ_GET, 32'h0000_000A, 32'h0000_0022, 32'h0000_0010);
		send_request(REQ_GET, 32'h0000_000B, 32'h0000_0033, 32'h0000_0011);

		for (phase = 0; phase < 8; phase++) begin
			write_limit(phase_limit[phase]);
			src_steady = (phase == 4 || phase == 5);
			snk_steady = (phase == 4 || phase == 6);
			if (phase == 2)
				hold_req = 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) == 0)
					drain();
				random_item();
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
